// ----- rtl/pubc_pkg.sv -----
package pubc_pkg;

  localparam int LOOKAHEAD_BYTES = 4;
  localparam int COUNT_WIDTH_DEF = 10;
  localparam int SIZE_W          = 10;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 10;
  localparam int ENTRY_BYTES     = 5;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_ENABLE   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_SIZE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUPS_PER_LINE = 8'd3;

  localparam logic [SIZE_W-1:0] GROUP_SIZE_RST      = 10'd8;
  localparam logic [SIZE_W-1:0] GROUPS_PER_LINE_RST = 10'd10;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } pubc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } pubc_out_t;

  typedef struct packed {
    logic              dec_sel;
    logic              format_enable;
    logic [SIZE_W-1:0] grp_len;
    logic [SIZE_W-1:0] line_len;
  } pubc_cfg_t;

  // one queued job: up to five bytes for the back end to send
  typedef struct packed {
    logic                       last;
    logic [2:0]                 n;
    logic [ENTRY_BYTES-1:0][7:0] bytes;
  } pubc_entry_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pubc_glyph_t;

  typedef struct packed {
    logic       found;
    logic [7:0] raw;
  } pubc_lookup_t;

  function automatic pubc_glyph_t mk2(logic [7:0] a, logic [7:0] b);
    pubc_glyph_t g;
    g.len = 2'd2; g.b0 = a; g.b1 = b; g.b2 = 8'h00;
    return g;
  endfunction

  function automatic pubc_glyph_t mk3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pubc_glyph_t g;
    g.len = 2'd3; g.b0 = a; g.b1 = b; g.b2 = c;
    return g;
  endfunction

  function automatic pubc_glyph_t glyph_of(logic [7:0] v);
    pubc_glyph_t g;
    g.len = 2'd1; g.b0 = v; g.b1 = 8'h00; g.b2 = 8'h00;
    if (v == 8'd152) begin
      g = mk2(8'hc5, 8'h8c);
    end else if (v == 8'd184) begin
      g = mk2(8'hc5, 8'h8f);
    end else if (v >= 8'd192) begin
      g = mk2(8'hc4, v - 8'd64);
    end else if (v >= 8'd128) begin
      g = mk2(8'hc3, v);
    end else begin
      case (v)
        8'd0:    g = mk3(8'he2, 8'h88, 8'h85);
        8'd1:    g = mk2(8'hc2, 8'haf);
        8'd2:    g = mk2(8'hc2, 8'hab);
        8'd3:    g = mk2(8'hc2, 8'hbb);
        8'd4:    g = mk2(8'hcf, 8'h9e);
        8'd5:    g = mk2(8'hc2, 8'hbf);
        8'd6:    g = mk2(8'hc2, 8'ha1);
        8'd7:    g = mk2(8'hc2, 8'haa);
        8'd8:    g = mk3(8'he2, 8'h8c, 8'hab);
        8'd9:    g = mk3(8'he2, 8'h87, 8'ha5);
        8'd10:   g = mk3(8'he2, 8'h87, 8'ha9);
        8'd11:   g = mk3(8'he2, 8'h8a, 8'ha7);
        8'd12:   g = mk2(8'hc2, 8'ha7);
        8'd13:   g = mk3(8'he2, 8'h8f, 8'h8e);
        8'd14:   g = mk2(8'hc8, 8'haf);
        8'd15:   g = mk2(8'hca, 8'h98);
        8'd16:   g = mk2(8'hc6, 8'h94);
        8'd17:   g = mk2(8'hc2, 8'hb9);
        8'd18:   g = mk2(8'hc2, 8'hb2);
        8'd19:   g = mk2(8'hc2, 8'hba);
        8'd20:   g = mk2(8'hc2, 8'hb3);
        8'd21:   g = mk2(8'hc2, 8'hb5);
        8'd22:   g = mk2(8'hc9, 8'ha8);
        8'd23:   g = mk2(8'hc2, 8'hac);
        8'd24:   g = mk2(8'hc2, 8'ha9);
        8'd25:   g = mk2(8'hc2, 8'ha6);
        8'd26:   g = mk2(8'hc6, 8'hb5);
        8'd27:   g = mk3(8'he2, 8'h8e, 8'h8b);
        8'd28:   g = mk2(8'hce, 8'h9e);
        8'd29:   g = mk2(8'hc7, 8'h81);
        8'd30:   g = mk2(8'hc7, 8'h80);
        8'd31:   g = mk2(8'hc2, 8'hb6);
        8'd32:   g = mk3(8'he2, 8'h90, 8'ha3);
        8'd33:   g = mk3(8'hef, 8'hb9, 8'h97);
        8'd34:   g = mk2(8'hcb, 8'hb5);
        8'd35:   g = mk3(8'he2, 8'h99, 8'haf);
        8'd36:   g = mk3(8'hef, 8'hb9, 8'ha9);
        8'd37:   g = mk3(8'hef, 8'hb9, 8'haa);
        8'd38:   g = mk3(8'hef, 8'hb9, 8'ha0);
        8'd39:   g = mk2(8'hca, 8'hbc);
        8'd40:   g = mk3(8'he2, 8'h9d, 8'ha8);
        8'd41:   g = mk3(8'he2, 8'h9d, 8'ha9);
        8'd42:   g = mk3(8'hef, 8'hb9, 8'ha1);
        8'd43:   g = mk3(8'hef, 8'hb9, 8'ha2);
        8'd45:   g = mk3(8'hef, 8'hb9, 8'ha3);
        8'd47:   g = mk3(8'he2, 8'h81, 8'h84);
        8'd58:   g = mk3(8'hef, 8'hb9, 8'h95);
        8'd59:   g = mk3(8'hef, 8'hb9, 8'h94);
        8'd61:   g = mk3(8'hef, 8'hb9, 8'ha6);
        8'd63:   g = mk3(8'hef, 8'hb9, 8'h96);
        8'd64:   g = mk3(8'hef, 8'hb9, 8'hab);
        8'd91:   g = mk3(8'he2, 8'h9f, 8'ha6);
        8'd92:   g = mk3(8'he2, 8'ha7, 8'hb9);
        8'd93:   g = mk3(8'he2, 8'h9f, 8'ha7);
        8'd96:   g = mk2(8'hcb, 8'h8b);
        8'd123:  g = mk3(8'he2, 8'h9d, 8'hb4);
        8'd124:  g = mk3(8'he2, 8'h88, 8'ha3);
        8'd125:  g = mk3(8'he2, 8'h9d, 8'hb5);
        8'd126:  g = mk2(8'hcb, 8'h9c);
        8'd127:  g = mk3(8'he2, 8'h8c, 8'ha6);
        default: g.len = 2'd1;
      endcase
    end
    return g;
  endfunction

  function automatic logic [15:0] glyph_hash(pubc_glyph_t g);
    logic [15:0] h;
    case (g.len)
      2'd1:    h = {8'h00, g.b0};
      2'd2:    h = {g.b0, g.b1};
      2'd3:    h = {g.b0[3:0], g.b1[5:0], g.b2[5:0]};
      default: h = 16'h0000;
    endcase
    return h;
  endfunction

  // reverse map over the constant glyph table, highest byte wins
  function automatic pubc_lookup_t lookup_hash(logic [15:0] h);
    pubc_lookup_t r;
    pubc_glyph_t  g;
    r = '0;
    for (int v = 0; v < 256; v++) begin
      g = glyph_of(8'(v));
      if (glyph_hash(g) == h) begin
        r.found = 1'b1;
        r.raw   = 8'(v);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/pubc_queue.sv -----
module pubc_queue
  import pubc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  pubc_entry_t wr_data,
  output logic        rd_valid,
  input  logic        rd_ready,
  output pubc_entry_t rd_data
);

  pubc_entry_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ----- rtl/pubc_front.sv -----
module pubc_front
  import pubc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pubc_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  pubc_in_t    in_data,
  output logic        q_valid,
  input  logic        q_ready,
  output pubc_entry_t q_data
);

  localparam int CMP_W = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEC  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [LOOKAHEAD_BYTES-1:0][7:0]     pend_r, pend_nxt;
  logic [2:0]                          pcnt_r, pcnt_nxt;
  logic [3:0][7:0]                     res_r, res_nxt;
  logic [2:0]                          res_n_r, res_n_nxt;
  logic                                last_r, last_nxt;
  logic [COUNT_WIDTH-1:0]              gig_r, gig_nxt, gil_r, gil_nxt;
  logic                                any_r, any_nxt;

  // encode path
  pubc_glyph_t            g;
  logic                   sep, nl;
  logic [COUNT_WIDTH-1:0] gil_inc, gig_base;
  pubc_entry_t            enc_e, dec_e;

  // decode path
  logic [7:0]   head;
  logic [1:0]   need, eff;
  logic         hi, short_buf, dec_done;
  pubc_lookup_t l1, l2, l3;
  logic         take1, take2, take3, made;
  logic [7:0]   raw;
  logic [1:0]   drop;
  logic         ws;
  logic         accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    g   = glyph_of(in_data.data_byte);
    sep = cfg.format_enable && any_r &&
          (CMP_W'(gig_r) >= CMP_W'(cfg.grp_len));
    gil_inc = (gil_r == CNT_MAX) ? gil_r : gil_r + 1'b1;
    nl  = sep && (CMP_W'(gil_inc) >= CMP_W'(cfg.line_len));
    gig_base = sep ? '0 : gig_r;

    enc_e.last  = in_data.stream_last;
    enc_e.n     = {1'b0, g.len} + {2'b00, sep} + {2'b00, nl};
    enc_e.bytes = '0;
    if (nl) begin
      enc_e.bytes = {g.b2, g.b1, g.b0, CH_LF, CH_SPACE};
    end else if (sep) begin
      enc_e.bytes = {8'h00, g.b2, g.b1, g.b0, CH_SPACE};
    end else begin
      enc_e.bytes = {8'h00, 8'h00, g.b2, g.b1, g.b0};
    end

    dec_e.last  = last_r;
    dec_e.n     = res_n_r;
    dec_e.bytes = {8'h00, res_r};
  end

  always_comb begin
    head = pend_r[0];
    hi   = (head >= 8'hF0);
    if (head < 8'h80) begin
      need = 2'd1;
    end else if (head < 8'hE0) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    short_buf = (pcnt_r < {1'b0, need});
    eff       = short_buf ? pcnt_r[1:0] : need;
    dec_done  = (pcnt_r == 3'd0) || (!hi && short_buf && !last_r);

    l1 = lookup_hash({8'h00, head});
    l2 = lookup_hash({head, pend_r[1]});
    l3 = lookup_hash({head[3:0], pend_r[1][5:0], pend_r[2][5:0]});

    take3 = !hi && (eff == 2'd3) && l3.found;
    take2 = !hi && !take3 && (eff >= 2'd2) && l2.found;
    take1 = !hi && !take3 && !take2 && (eff >= 2'd1) && l1.found;
    made  = take1 || take2 || take3;
    raw   = take3 ? l3.raw : (take2 ? l2.raw : l1.raw);
    drop  = take3 ? 2'd3 : (take2 ? 2'd2 : 2'd1);

    ws = (in_data.data_byte == CH_SPACE) || (in_data.data_byte == CH_TAB) ||
         (in_data.data_byte == CH_LF) || (in_data.data_byte == CH_CR);
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    res_nxt   = res_r;
    res_n_nxt = res_n_r;
    last_nxt  = last_r;
    gig_nxt   = gig_r;
    gil_nxt   = gil_r;
    any_nxt   = any_r;
    in_ready  = 1'b0;
    q_valid   = 1'b0;
    q_data    = enc_e;

    case (state_r)
      ST_IDLE: begin
        in_ready = cfg.dec_sel || q_ready;
        q_valid  = in_valid && !cfg.dec_sel;
        if (accept) begin
          if (!cfg.dec_sel) begin
            if (cfg.format_enable) begin
              if (sep) begin
                gil_nxt = nl ? '0 : gil_inc;
              end
              gig_nxt = (gig_base == CNT_MAX) ? gig_base : gig_base + 1'b1;
            end
            any_nxt = 1'b1;
            if (in_data.stream_last) begin
              pcnt_nxt = 3'd0;
              gig_nxt  = '0;
              gil_nxt  = '0;
              any_nxt  = 1'b0;
            end
          end else begin
            if (!ws && (pcnt_r < 3'(LOOKAHEAD_BYTES))) begin
              pend_nxt[pcnt_r[1:0]] = in_data.data_byte;
              pcnt_nxt = pcnt_r + 3'd1;
            end
            last_nxt  = in_data.stream_last;
            res_n_nxt = 3'd0;
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (dec_done) begin
          if (res_n_r != 3'd0) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_IDLE;
            if (last_r) begin
              pcnt_nxt = 3'd0;
              gig_nxt  = '0;
              gil_nxt  = '0;
              any_nxt  = 1'b0;
            end
          end
        end else begin
          pend_nxt = pend_r >> {drop, 3'b000};
          pcnt_nxt = pcnt_r - {1'b0, drop};
          if (made) begin
            res_nxt[res_n_r[1:0]] = raw;
            res_n_nxt = res_n_r + 3'd1;
          end
        end
      end
      ST_PUSH: begin
        q_valid = 1'b1;
        q_data  = dec_e;
        if (q_ready) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            pcnt_nxt = 3'd0;
            gig_nxt  = '0;
            gil_nxt  = '0;
            any_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    res_r   <= res_nxt;
    res_n_r <= res_n_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pcnt_r  <= 3'd0;
      gig_r   <= '0;
      gil_r   <= '0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pcnt_r  <= pcnt_nxt;
      gig_r   <= gig_nxt;
      gil_r   <= gil_nxt;
      any_r   <= any_nxt;
    end
  end

endmodule

// ----- rtl/pubc_back.sv -----
module pubc_back
  import pubc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  pubc_entry_t q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pubc_out_t   out_data
);

  pubc_entry_t cur_r;
  logic        cur_valid_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  pubc_out_t   out_r;
  logic        load, fin;

  assign load    = cur_valid_r && (!out_valid_r || out_ready);
  assign fin     = (idx_r == cur_r.n - 3'd1);
  assign q_ready = !cur_valid_r || (load && fin);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_r <= q_data;
    end
    if (load) begin
      out_r.out_byte   <= cur_r.bytes[idx_r];
      out_r.run_last   <= fin;
      out_r.stream_end <= fin && cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_ready) begin
        cur_valid_r <= q_valid;
        idx_r       <= 3'd0;
      end else if (load) begin
        idx_r <= idx_r + 3'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/printable_utf8_byte_codec.sv -----
// Printable byte codec. In encode mode each input byte turns into a one- to
// three-byte UTF-8 glyph, with an optional space before each new group and a
// space plus LF before each new line; in decode mode whitespace is dropped and
// glyph text is matched back to raw bytes, with stream_last flushing whatever
// is still pending. The front end takes one encode beat per cycle while the
// queue has room and hands a job of up to five bytes to a two-deep queue; a
// decode beat holds the front until it is through: the byte is captured, the
// buffer is decoded one decision at a time until nothing more can be taken,
// and any result is then queued. The back end sends one output byte per cycle
// while out_ready is held, so in encode mode the sustained rate is set by the
// number of bytes each item produces, one to five.
module printable_utf8_byte_codec
  import pubc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pubc_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pubc_out_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pubc_cfg_t   cfg_r;
  logic        q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  pubc_entry_t q_in_data, q_out_data;

  // register writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dec_sel       <= 1'b0;
      cfg_r.format_enable <= 1'b0;
      cfg_r.grp_len       <= GROUP_SIZE_RST;
      cfg_r.line_len      <= GROUPS_PER_LINE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DECODE_MODE:     cfg_r.dec_sel       <= cfg_data[0];
        REG_FORMAT_ENABLE:   cfg_r.format_enable <= cfg_data[0];
        REG_GROUP_SIZE:      cfg_r.grp_len       <= cfg_data[SIZE_W-1:0];
        REG_GROUPS_PER_LINE: cfg_r.line_len      <= cfg_data[SIZE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // classify and build jobs
  pubc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  // decouples the two sides
  pubc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  // byte serializer with output register
  pubc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // end of stream is always also end of a run
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream_end without run_last");

  // every queued job carries at least one byte
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_in_valid && q_in_ready |-> q_in_data.n != 3'd0)
    else $error("empty job queued");

  // output empty right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output beat right after reset");

endmodule

// ----- test/tb_printable_utf8_byte_codec.sv -----
module tb_printable_utf8_byte_codec;
  import pubc_pkg::*;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  pubc_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  pubc_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  printable_utf8_byte_codec DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam logic [9:0] COUNT_MAX = 10'h3FF;
  // longest path from an accepted beat to its last output byte, with margin
  localparam int SETTLE_CYCLES = 24;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state: registers, lookahead buffer, format counters
  logic       mode_dec;
  logic       fmt_on;
  logic [9:0] grp_size;
  logic [9:0] line_groups;
  logic [7:0] pend_q[$];
  logic [9:0] glyph_cnt;
  logic [9:0] group_cnt;
  logic       emitted;

  // reverse glyph map, hash to raw byte
  logic [7:0] raw_of_hash[int];

  pubc_out_t  expected_q[$];
  int         errs = 0;
  int         n_beats = 0;
  int         n_bytes_out = 0;
  int         n_enc_beats = 0;
  int         n_dec_beats = 0;
  bit         quiet = 1'b0;

  // glyph as {length, b0, b1, b2}
  function automatic logic [31:0] glyph_word(logic [7:0] v);
    logic [31:0] w;
    if (v == 8'd152)      w = 32'h02c58c00;
    else if (v == 8'd184) w = 32'h02c58f00;
    else if (v >= 8'd192) w = {8'd2, 8'hc4, v - 8'd64, 8'h00};
    else if (v >= 8'd128) w = {8'd2, 8'hc3, v, 8'h00};
    else begin
      case (v)
        8'd0:   w = 32'h03e28885;  8'd1:   w = 32'h02c2af00;
        8'd2:   w = 32'h02c2ab00;  8'd3:   w = 32'h02c2bb00;
        8'd4:   w = 32'h02cf9e00;  8'd5:   w = 32'h02c2bf00;
        8'd6:   w = 32'h02c2a100;  8'd7:   w = 32'h02c2aa00;
        8'd8:   w = 32'h03e28cab;  8'd9:   w = 32'h03e287a5;
        8'd10:  w = 32'h03e287a9;  8'd11:  w = 32'h03e28aa7;
        8'd12:  w = 32'h02c2a700;  8'd13:  w = 32'h03e28f8e;
        8'd14:  w = 32'h02c8af00;  8'd15:  w = 32'h02ca9800;
        8'd16:  w = 32'h02c69400;  8'd17:  w = 32'h02c2b900;
        8'd18:  w = 32'h02c2b200;  8'd19:  w = 32'h02c2ba00;
        8'd20:  w = 32'h02c2b300;  8'd21:  w = 32'h02c2b500;
        8'd22:  w = 32'h02c9a800;  8'd23:  w = 32'h02c2ac00;
        8'd24:  w = 32'h02c2a900;  8'd25:  w = 32'h02c2a600;
        8'd26:  w = 32'h02c6b500;  8'd27:  w = 32'h03e28e8b;
        8'd28:  w = 32'h02ce9e00;  8'd29:  w = 32'h02c78100;
        8'd30:  w = 32'h02c78000;  8'd31:  w = 32'h02c2b600;
        8'd32:  w = 32'h03e290a3;  8'd33:  w = 32'h03efb997;
        8'd34:  w = 32'h02cbb500;  8'd35:  w = 32'h03e299af;
        8'd36:  w = 32'h03efb9a9;  8'd37:  w = 32'h03efb9aa;
        8'd38:  w = 32'h03efb9a0;  8'd39:  w = 32'h02cabc00;
        8'd40:  w = 32'h03e29da8;  8'd41:  w = 32'h03e29da9;
        8'd42:  w = 32'h03efb9a1;  8'd43:  w = 32'h03efb9a2;
        8'd45:  w = 32'h03efb9a3;  8'd47:  w = 32'h03e28184;
        8'd58:  w = 32'h03efb995;  8'd59:  w = 32'h03efb994;
        8'd61:  w = 32'h03efb9a6;  8'd63:  w = 32'h03efb996;
        8'd64:  w = 32'h03efb9ab;  8'd91:  w = 32'h03e29fa6;
        8'd92:  w = 32'h03e2a7b9;  8'd93:  w = 32'h03e29fa7;
        8'd96:  w = 32'h02cb8b00;  8'd123: w = 32'h03e29db4;
        8'd124: w = 32'h03e288a3;  8'd125: w = 32'h03e29db5;
        8'd126: w = 32'h02cb9c00;  8'd127: w = 32'h03e28ca6;
        default: w = {8'd1, v, 16'h0000};
      endcase
    end
    return w;
  endfunction

  // hash of the first len buffered bytes
  function automatic int seq_hash(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int len);
    if (len == 1) return int'(b0);
    if (len == 2) return int'({b0, b1});
    return int'({b0[3:0], b1[5:0], b2[5:0]});
  endfunction

  // work out the output bytes of one accepted beat and update state
  task automatic predict_codec(input logic [7:0] b, input bit last, output logic [7:0] res[$]);
    logic [31:0] g;
    logic [7:0]  head;
    int          need;
    int          h;
    bit          hit;
    res = {};
    if (!mode_dec) begin
      g = glyph_word(b);
      if (fmt_on) begin
        if (emitted && glyph_cnt >= grp_size) begin
          res.push_back(CH_SPACE);
          glyph_cnt = '0;
          if (group_cnt < COUNT_MAX) group_cnt++;
          if (group_cnt >= line_groups) begin
            res.push_back(CH_LF);
            group_cnt = '0;
          end
        end
        if (glyph_cnt < COUNT_MAX) glyph_cnt++;
      end
      res.push_back(g[23:16]);
      if (g[31:24] > 1) res.push_back(g[15:8]);
      if (g[31:24] > 2) res.push_back(g[7:0]);
      emitted = 1'b1;
    end else begin
      if (!(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) &&
          pend_q.size() < LOOKAHEAD_BYTES)
        pend_q.push_back(b);
      while (pend_q.size() > 0 && res.size() < 5) begin
        head = pend_q[0];
        if (head >= 8'hF0) begin
          void'(pend_q.pop_front());
          continue;
        end
        need = head < 8'h80 ? 1 : (head < 8'hE0 ? 2 : 3);
        if (pend_q.size() < need) begin
          if (!last) break;
          need = pend_q.size();
        end
        hit = 1'b0;
        for (int len = need; len >= 1 && !hit; len--) begin
          h = seq_hash(pend_q[0], len > 1 ? pend_q[1] : 8'h00,
                       len > 2 ? pend_q[2] : 8'h00, len);
          if (raw_of_hash.exists(h)) begin
            res.push_back(raw_of_hash[h]);
            repeat (len) void'(pend_q.pop_front());
            hit = 1'b1;
          end
        end
        if (!hit) void'(pend_q.pop_front());
      end
    end
    if (last) begin
      pend_q    = {};
      glyph_cnt = '0;
      group_cnt = '0;
      emitted   = 1'b0;
    end
  endtask

  // stall bursts on the result side
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker: every output beat against the oldest expectation
  always @(posedge clk) begin
    pubc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_bytes_out++;
      if (expected_q.size() == 0) begin
        $error("unexpected output beat: out_byte=%h", out_data.out_byte);
        errs++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
          errs++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, out_data.run_last);
          errs++;
        end
        if (out_data.stream_end !== want.stream_end) begin
          $error("stream_end: expected %b, actual %b", want.stream_end, out_data.stream_end);
          errs++;
        end
      end
    end
  end

  // drive one input beat; typed bytes replace the predictor's where given
  task automatic send_byte(input logic [7:0] b, input bit last,
                           input int typed_n = 0, input logic [23:0] typed = '0);
    logic [7:0] res[$];
    pubc_out_t  o;
    in_data.data_byte   = b;
    in_data.stream_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_codec(b, last, res);
    n_beats++;
    if (mode_dec) n_dec_beats++; else n_enc_beats++;
    if (typed_n != 0) begin
      res = {};
      for (int k = 0; k < typed_n; k++) res.push_back(typed[23 - 8*k -: 8]);
    end
    foreach (res[k]) begin
      o.out_byte   = res[k];
      o.run_last   = (k == res.size() - 1);
      o.stream_end = (k == res.size() - 1) && last;
      expected_q.push_back(o);
    end
    @(negedge clk);
    in_valid = 1'b0;
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  // wait until every expected byte has come and the block has settled
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DECODE_MODE:     mode_dec    = val[0];
      REG_FORMAT_ENABLE:   fmt_on      = val[0];
      REG_GROUP_SIZE:      grp_size    = val;
      REG_GROUPS_PER_LINE: line_groups = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // directed table
  typedef struct {
    bit                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [7:0]           b;
    bit                   last;
    int                   typed_n;
    logic [23:0]          typed;
  } step_row_t;

  step_row_t rows[$];

  task automatic add_beat(logic [7:0] b, bit last, int n = 0, logic [23:0] t = '0);
    rows.push_back('{1'b0, '0, '0, b, last, n, t});
  endtask

  task automatic add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    rows.push_back('{1'b1, idx, val, 8'h00, 1'b0, 0, '0});
  endtask

  initial begin
    logic [7:0]  text[$];
    logic [31:0] g;
    logic [7:0]  wsp[4];
    bit          dec_phase;
    int          sel;
    int          sizes[5];

    mode_dec    = 1'b0;
    fmt_on      = 1'b0;
    grp_size    = GROUP_SIZE_RST;
    line_groups = GROUPS_PER_LINE_RST;
    glyph_cnt   = '0;
    group_cnt   = '0;
    emitted     = 1'b0;
    wsp = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    sizes = '{0, 1, 2, 3, 1023};
    // later bytes overwrite earlier ones, so the highest byte wins a shared hash
    for (int v = 0; v < 256; v++) begin
      g = glyph_word(8'(v));
      raw_of_hash[seq_hash(g[23:16], g[15:8], g[7:0], int'(g[31:24]))] = 8'(v);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // encode at reset settings, format off: glyphs read straight off the map
    add_beat(8'd0,   1'b0, 3, 24'he28885);
    add_beat(8'd255, 1'b0, 2, 24'hc4bf00);
    add_beat(8'd152, 1'b0, 2, 24'hc58c00);
    add_beat(8'd184, 1'b0, 2, 24'hc58f00);
    add_beat(8'd128, 1'b0, 2, 24'hc38000);
    add_beat(8'd32,  1'b0, 3, 24'he290a3);
    add_beat(8'd65,  1'b1, 1, 24'h410000);
    // smallest groups and lines: space and newline before every glyph after the first
    add_cfg(REG_FORMAT_ENABLE, 10'd1);
    add_cfg(REG_GROUP_SIZE, 10'd1);
    add_cfg(REG_GROUPS_PER_LINE, 10'd1);
    add_beat(8'd65, 1'b0);
    add_beat(8'd191, 1'b0);
    add_beat(8'd127, 1'b1);
    // largest sizes, plus a write to an unused index that must be ignored
    add_cfg(REG_GROUP_SIZE, 10'd1023);
    add_cfg(REG_GROUPS_PER_LINE, 10'd1023);
    add_cfg(8'd9, 10'd5);
    add_beat(8'd0, 1'b0);
    add_beat(8'd200, 1'b1);
    // decode: whole glyph, whitespace, bad head, lone ascii, truncated tail flushed
    add_cfg(REG_DECODE_MODE, 10'd1);
    add_beat(8'he2, 1'b0);
    add_beat(8'h88, 1'b0);
    add_beat(8'h85, 1'b0);
    add_beat(CH_SPACE, 1'b0);
    add_beat(CH_TAB, 1'b0);
    add_beat(CH_LF, 1'b0);
    add_beat(CH_CR, 1'b0);
    add_beat(8'hc3, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hf5, 1'b0);
    add_beat(8'h41, 1'b0);
    add_beat(8'he2, 1'b0);
    add_beat(8'hc3, 1'b1);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_byte(rows[i].b, rows[i].last, rows[i].typed_n, rows[i].typed);
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 7);
      dec_phase = ph[0];
      write_reg(REG_DECODE_MODE, {9'd0, dec_phase});
      write_reg(REG_FORMAT_ENABLE, {9'd0, 1'($urandom_range(0, 3) != 0)});
      write_reg(REG_GROUP_SIZE, $urandom_range(0, 1) ? 10'(sizes[$urandom_range(0, 4)])
                                                     : 10'($urandom_range(1, 12)));
      write_reg(REG_GROUPS_PER_LINE, $urandom_range(0, 1) ? 10'(sizes[$urandom_range(0, 4)])
                                                          : 10'($urandom_range(1, 6)));
      if (ph == 7) write_reg(8'($urandom_range(4, 255)), 10'($urandom));
      text = {};
      if (!dec_phase) begin
        repeat (55) text.push_back(8'($urandom));
      end else begin
        // mostly well-formed glyph text, some whitespace, noise and cut glyphs
        while (text.size() < 55) begin
          g = glyph_word(8'($urandom));
          sel = $urandom_range(0, 19);
          if (sel < 2) text.push_back(wsp[$urandom_range(0, 3)]);
          else if (sel == 2) text.push_back(8'($urandom));
          else begin
            text.push_back(g[23:16]);
            if (g[31:24] > 1) text.push_back(g[15:8]);
            if (g[31:24] > 2 && sel != 3) text.push_back(g[7:0]);
          end
        end
      end
      foreach (text[i]) begin
        // hold the sender once until the block has emptied
        if (ph == 2 && i == 25) drain();
        send_byte(text[i], (i == text.size() - 1) ? 1'($urandom_range(0, 1))
                                                 : ($urandom_range(0, 39) == 0));
      end
    end

    drain();
    $display("covered %0d beats (%0d encode, %0d decode) and %0d output bytes",
             n_beats, n_enc_beats, n_dec_beats, n_bytes_out);
    $display("register settings swept across modes, format on and off, sizes 0 to 1023");
    if (errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
